[rtl/core/fbab_pkg.sv]
// shared types, constants and pixel functions for the rgb565 frame store
// no dependencies
package fbab_pkg;

   localparam int unsigned MAX_PIXELS  = 131072;
   localparam int unsigned ADDR_W      = $clog2(MAX_PIXELS);
   localparam int unsigned DIM_W       = 11;
   localparam int unsigned POS_W       = 12;
   localparam int unsigned COLOUR_W    = 16;
   localparam int unsigned ALPHA_W     = 8;
   localparam int unsigned PROD_W      = 2 * DIM_W;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0]        SPREAD_MASK  = 32'h07e0_f81f;
   localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [1:0] {
      MODE_DRAW  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_DIRTY = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_SWAP   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             swap;
   } cfg_type;

   typedef struct packed {
      mode_type            mode;
      logic                clip;
      logic [ADDR_W-1:0]   addr;
      logic [COLOUR_W-1:0] colour;
      logic [ALPHA_W-1:0]  alpha;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   function automatic logic [COLOUR_W-1:0] swap16(input logic [COLOUR_W-1:0] v);
      return {v[7:0], v[15:8]};
   endfunction

   // spread both to 32 bits, weight 0..32, fold back
   function automatic logic [COLOUR_W-1:0] blend(input logic [COLOUR_W-1:0] fg,
                                                 input logic [COLOUR_W-1:0] bg,
                                                 input logic [ALPHA_W-1:0]  alpha);
      logic [ALPHA_W:0] w_sum;
      logic [5:0]       w;
      logic [31:0]      fg32;
      logic [31:0]      bg32;
      logic [31:0]      diff;
      logic [31:0]      prod;
      logic [31:0]      step;
      logic [31:0]      sum;
      w_sum = {1'b0, alpha} + (ALPHA_W+1)'(4);
      w     = w_sum[ALPHA_W:3];
      fg32  = {fg, fg} & SPREAD_MASK;
      bg32  = {bg, bg} & SPREAD_MASK;
      diff  = fg32 - bg32;
      prod  = diff * {26'd0, w};
      step  = (prod >> 5) & SPREAD_MASK;
      sum   = bg32 + step;
      return sum[15:0] | sum[31:16];
   endfunction

endpackage

[rtl/core/fbab_front.sv]
// front end: takes requests, clips them and forms the store address
// depends on fbab_pkg
module fbab_front (
   input  logic                          clock,
   input  logic                          reset,
   input  fbab_pkg::cfg_type             cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic [fbab_pkg::POS_W-1:0]    req_pos_x,
   input  logic [fbab_pkg::POS_W-1:0]    req_pos_y,
   input  logic [fbab_pkg::COLOUR_W-1:0] req_colour,
   input  logic [fbab_pkg::ALPHA_W-1:0]  req_alpha,
   output logic                          push_valid,
   output fbab_pkg::entry_type           push_entry,
   input  logic                          push_ready
);

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   fbab_pkg::mode_type            s1_mode_ff;
   logic                          s1_clip_ff;
   logic [fbab_pkg::PROD_W-1:0]   s1_prod_ff;
   logic [fbab_pkg::DIM_W-1:0]    s1_x_ff;
   logic [fbab_pkg::COLOUR_W-1:0] s1_colour_ff;
   logic [fbab_pkg::ALPHA_W-1:0]  s1_alpha_ff;

   logic                          accept;
   logic                          clip_in;
   logic [fbab_pkg::PROD_W-1:0]   prod_in;
   logic [fbab_pkg::PROD_W:0]     addr_full;
   logic                          out_of_store;

   assign req_ready = !s1_valid_ff || push_ready;
   assign accept    = req_valid && req_ready;

   // sign bit catches negatives, unsigned compare the far edges
   assign clip_in = req_pos_x[fbab_pkg::POS_W-1] || req_pos_y[fbab_pkg::POS_W-1] ||
                    (req_pos_x >= fbab_pkg::POS_W'(cfg.width)) ||
                    (req_pos_y >= fbab_pkg::POS_W'(cfg.height));

   assign prod_in = fbab_pkg::PROD_W'(req_pos_y[fbab_pkg::DIM_W-1:0]) *
                    fbab_pkg::PROD_W'(cfg.width);

   assign addr_full    = (fbab_pkg::PROD_W+1)'(s1_prod_ff) + (fbab_pkg::PROD_W+1)'(s1_x_ff);
   assign out_of_store = addr_full >= (fbab_pkg::PROD_W+1)'(fbab_pkg::MAX_PIXELS);

   assign push_valid        = s1_valid_ff;
   assign push_entry.mode   = s1_mode_ff;
   assign push_entry.clip   = s1_clip_ff || out_of_store;
   assign push_entry.addr   = addr_full[fbab_pkg::ADDR_W-1:0];
   assign push_entry.colour = s1_colour_ff;
   assign push_entry.alpha  = s1_alpha_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff   <= fbab_pkg::mode_type'(req_mode);
         s1_clip_ff   <= clip_in;
         s1_prod_ff   <= prod_in;
         s1_x_ff      <= req_pos_x[fbab_pkg::DIM_W-1:0];
         s1_colour_ff <= req_colour;
         s1_alpha_ff  <= req_alpha;
      end
   end

endmodule

[rtl/core/fbab_queue.sv]
// short queue of classified requests between front and back
// depends on fbab_pkg
module fbab_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   output logic                       push_ready,
   input  fbab_pkg::entry_type        push_entry,
   output logic                       pop_valid,
   input  logic                       pop,
   output fbab_pkg::entry_type        pop_entry,
   output fbab_pkg::queue_status_type status
);

   fbab_pkg::entry_type         entries_ff [fbab_pkg::QUEUE_DEPTH];
   logic [fbab_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [fbab_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [fbab_pkg::QCNT_W-1:0] count_ff;
   logic                        do_push;
   logic                        do_pop;

   assign push_ready = count_ff != fbab_pkg::QCNT_W'(fbab_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   assign status.not_empty = pop_valid;
   assign status.full      = !push_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == fbab_pkg::QPTR_W'(fbab_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == fbab_pkg::QPTR_W'(fbab_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/fbab_back.sv]
// back end: frame store, read-modify-write blend, dirty flag, response register
// depends on fbab_pkg
module fbab_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cfg_swap,
   input  logic                          q_valid,
   input  fbab_pkg::entry_type           q_entry,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fbab_pkg::COLOUR_W-1:0] rsp_pixel_value,
   output logic                          rsp_clipped,
   output logic                          rsp_was_dirty
);

   typedef enum logic {
      ST_IDLE,
      ST_WAIT
   } state_type;

   state_type                     state_ff;
   state_type                     state_in;
   fbab_pkg::entry_type           hold_ff;
   logic                          dirty_ff;
   logic                          dirty_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [fbab_pkg::COLOUR_W-1:0] rsp_pixel_ff;
   logic [fbab_pkg::COLOUR_W-1:0] rsp_pixel_in;
   logic                          rsp_clip_ff;
   logic                          rsp_clip_in;
   logic                          rsp_dirty_ff;

   logic [fbab_pkg::COLOUR_W-1:0] mem [fbab_pkg::MAX_PIXELS];
   logic [fbab_pkg::COLOUR_W-1:0] rd_data_ff;
   logic                          rd_en;
   logic                          wr_en;
   logic [fbab_pkg::ADDR_W-1:0]   wr_addr;
   logic [fbab_pkg::COLOUR_W-1:0] wr_data;

   logic                          out_free;
   logic                          need_read;
   logic                          finish;
   logic [fbab_pkg::COLOUR_W-1:0] bg;
   logic [fbab_pkg::COLOUR_W-1:0] blended;
   logic [fbab_pkg::COLOUR_W-1:0] blend_stored;
   logic [fbab_pkg::COLOUR_W-1:0] opaque_stored;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // a blend or a read needs the stored word first
   assign need_read = !q_entry.clip &&
                      (((q_entry.mode == fbab_pkg::MODE_DRAW) &&
                        (q_entry.alpha != fbab_pkg::ALPHA_OPAQUE)) ||
                       (q_entry.mode == fbab_pkg::MODE_READ));
   assign q_pop     = (state_ff == ST_IDLE) && q_valid && (need_read || out_free);
   assign rd_en     = q_pop && need_read;

   assign bg            = cfg_swap ? fbab_pkg::swap16(rd_data_ff) : rd_data_ff;
   assign blended       = fbab_pkg::blend(hold_ff.colour, bg, hold_ff.alpha);
   assign blend_stored  = cfg_swap ? fbab_pkg::swap16(blended) : blended;
   assign opaque_stored = cfg_swap ? fbab_pkg::swap16(q_entry.colour) : q_entry.colour;

   always_comb begin
      state_in     = state_ff;
      dirty_in     = dirty_ff;
      finish       = 1'b0;
      rsp_pixel_in = '0;
      rsp_clip_in  = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = q_entry.addr;
      wr_data      = opaque_stored;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop && need_read) begin
               state_in = ST_WAIT;
            end else if (q_pop) begin
               finish = 1'b1;
               unique case (q_entry.mode)
                  fbab_pkg::MODE_DRAW: begin
                     if (q_entry.clip) begin
                        rsp_clip_in = 1'b1;
                     end else begin
                        rsp_pixel_in = opaque_stored;
                        wr_en        = 1'b1;
                        dirty_in     = 1'b1;
                     end
                  end
                  fbab_pkg::MODE_READ:  rsp_clip_in = 1'b1;
                  fbab_pkg::MODE_DIRTY: dirty_in    = 1'b0;
                  fbab_pkg::MODE_NONE:  ;
               endcase
            end
         end
         ST_WAIT: begin
            wr_addr = hold_ff.addr;
            wr_data = blend_stored;
            if (out_free) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
               if (hold_ff.mode == fbab_pkg::MODE_DRAW) begin
                  rsp_pixel_in = blend_stored;
                  wr_en        = 1'b1;
                  dirty_in     = 1'b1;
               end else begin
                  rsp_pixel_in = rd_data_ff;
               end
            end
         end
      endcase
      rsp_valid_in = finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rd_en) begin
            hold_ff <= q_entry;
         end
         if (finish) begin
            rsp_pixel_ff <= rsp_pixel_in;
            rsp_clip_ff  <= rsp_clip_in;
            rsp_dirty_ff <= dirty_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[q_entry.addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_ff;
   assign rsp_clipped     = rsp_clip_ff;
   assign rsp_was_dirty   = rsp_dirty_ff;

endmodule

[rtl/core/framebuffer_rgb565_alpha_blend.sv]
// rgb565 frame store with clipped draw, alpha blend, read-back and dirty flag
// path: front stage, queue, response register; reads and blends add the store read register
// the back end takes no new request while it finishes one that reads the store
// the front end clips and multiplies y by the row stride in its own stage, decoupled by a queue
// reset is synchronous: clears control, the dirty flag and the registers to 240, 320, 1;
// the frame store is not cleared and needs no clearing pass
module framebuffer_rgb565_alpha_blend (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [1:0]                    csr_index,
   input  logic [fbab_pkg::DIM_W-1:0]    csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic [fbab_pkg::POS_W-1:0]    req_pos_x,
   input  logic [fbab_pkg::POS_W-1:0]    req_pos_y,
   input  logic [fbab_pkg::COLOUR_W-1:0] req_colour,
   input  logic [fbab_pkg::ALPHA_W-1:0]  req_alpha,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fbab_pkg::COLOUR_W-1:0] rsp_pixel_value,
   output logic                          rsp_clipped,
   output logic                          rsp_was_dirty
);

   fbab_pkg::cfg_type          cfg_ff;
   logic                       push_valid;
   logic                       push_ready;
   fbab_pkg::entry_type        push_entry;
   logic                       q_valid;
   logic                       q_pop;
   fbab_pkg::entry_type        q_entry;
   fbab_pkg::queue_status_type q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= fbab_pkg::DIM_W'(240);
         cfg_ff.height <= fbab_pkg::DIM_W'(320);
         cfg_ff.swap   <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            fbab_pkg::CSR_WIDTH:  cfg_ff.width  <= csr_wr_data;
            fbab_pkg::CSR_HEIGHT: cfg_ff.height <= csr_wr_data;
            fbab_pkg::CSR_SWAP:   cfg_ff.swap   <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   fbab_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .req_pos_x  (req_pos_x),
      .req_pos_y  (req_pos_y),
      .req_colour (req_colour),
      .req_alpha  (req_alpha),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   fbab_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_entry  (q_entry),
      .status     (q_status)
   );

   fbab_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg_swap        (cfg_ff.swap),
      .q_valid         (q_valid),
      .q_entry         (q_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_clipped     (rsp_clipped),
      .rsp_was_dirty   (rsp_was_dirty)
   );

   // a clipped request never carries a pixel
   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_pixel_value == '0)
      else $error("clipped response with non-zero pixel");

   // nothing is left over from before reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !q_status.not_empty)
      else $error("response or queued request after reset");

   // a full queue must also read as non-empty
   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> q_status.not_empty)
      else $error("queue full and empty at once");

   // the back end only pops what is there
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from an empty queue");

endmodule
